// File: sv/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/mtsw_pkg.sv
package mtsw_pkg;

    localparam int MAX_DIM         = 1024;
    localparam int CNT_W           = $clog2(MAX_DIM);
    localparam int DIM_W           = CNT_W + 1;
    localparam int ORG_W           = 10;
    localparam int SIZE_W          = 11;
    localparam int PIXEL_W         = 32;
    localparam int OFFSET_W        = 22;
    localparam int PIXEL_BYTES     = 4;
    localparam int BPP_SHIFT       = $clog2(PIXEL_BYTES);
    localparam int IDX_W           = OFFSET_W - BPP_SHIFT;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = SIZE_W;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REGION_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SURFACE_HEIGHT = 3'd5;

    typedef struct packed {
        logic [ORG_W-1:0]  origin_x;
        logic [ORG_W-1:0]  origin_y;
        logic [SIZE_W-1:0] region_width;
        logic [SIZE_W-1:0] region_height;
        logic [SIZE_W-1:0] surface_width;
        logic [SIZE_W-1:0] surface_height;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] row;
    } pos_t;

endpackage

// File: sv/mtsw_if.sv
interface mtsw_pix_if;
    logic                            valid;
    logic                            ready;
    logic [mtsw_pkg::PIXEL_W-1:0]    pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink (input valid, input pixel_in, output ready);
endinterface

interface mtsw_res_if;
    logic                            valid;
    logic                            ready;
    logic [mtsw_pkg::OFFSET_W-1:0]   tiled_offset;
    logic [mtsw_pkg::PIXEL_W-1:0]    pixel_out;
    logic                            region_last;
    logic                            out_of_range;

    modport source (output valid, output tiled_offset, output pixel_out,
                    output region_last, output out_of_range, input ready);
    modport sink (input valid, input tiled_offset, input pixel_out,
                  input region_last, input out_of_range, output ready);
endinterface

// File: sv/mtsw_addr.sv
module mtsw_addr
(
    input  mtsw_pkg::cfg_t                  cfg,
    input  mtsw_pkg::pos_t                  pos,
    output logic [mtsw_pkg::OFFSET_W-1:0]   tiled_offset,
    output logic                            out_of_range
);

    localparam int PX_W = ((mtsw_pkg::CNT_W > mtsw_pkg::ORG_W) ?
                           mtsw_pkg::CNT_W : mtsw_pkg::ORG_W) + 1;
    localparam int PY_W = ((mtsw_pkg::SIZE_W > PX_W) ? mtsw_pkg::SIZE_W : PX_W) + 2;
    localparam int PROD_W = 2 * mtsw_pkg::SIZE_W;

    logic [PX_W-1:0]                px;
    logic [PY_W-1:0]                py;
    logic [mtsw_pkg::SIZE_W-1:0]    uy;
    logic [5:0]                     morton;
    logic [PROD_W-1:0]              row_base;
    logic [mtsw_pkg::IDX_W-1:0]     col_base;
    logic [mtsw_pkg::IDX_W-1:0]     idx;

    assign px = PX_W'(pos.col) + PX_W'(cfg.origin_x);
    // flipped row, sign bit marks a row above the surface top
    assign py = PY_W'(cfg.surface_height) - PY_W'(1) - PY_W'(pos.row)
              - PY_W'(cfg.origin_y);
    assign out_of_range = py[PY_W-1];
    assign uy = py[mtsw_pkg::SIZE_W-1:0];

    // z-order inside the 8x8 tile: x0 y0 x1 y1 x2 y2 from the lsb up
    assign morton = {uy[2], px[2], uy[1], px[1], uy[0], px[0]};

    assign col_base = mtsw_pkg::IDX_W'({px[PX_W-1:3], 6'b000000});
    assign row_base = {uy[mtsw_pkg::SIZE_W-1:3], 3'b000} * cfg.surface_width;
    assign idx = col_base + mtsw_pkg::IDX_W'(morton) + row_base[mtsw_pkg::IDX_W-1:0];

    assign tiled_offset = out_of_range ? '0 : {idx, {mtsw_pkg::BPP_SHIFT{1'b0}}};

endmodule

// File: sv/morton_tile_address_swizzler_unit.sv
// pipeline: the input stage registers pixel and position, the result stage the tiled address
// throughput: one pixel per cycle if dst is ready; two pixels in flight; stall backs up one stage
// address path: one 11x11 multiply and a 20-bit add between the two register stages
// reset: rst_n asynchronous active low; clears both stages, the column and row counters,
// and loads the registers with origin 0,0, region 1x1 and surface 8x8
`include "assert_macros.svh"

module morton_tile_address_swizzler_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    mtsw_pix_if.sink                            src,
    mtsw_res_if.source                          dst,
    input  logic                                cfg_we,
    input  logic [mtsw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mtsw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CNT_W = mtsw_pkg::CNT_W;
    localparam int DIM_W = mtsw_pkg::DIM_W;

    mtsw_pkg::cfg_t                 cfg_reg;
    logic [CNT_W-1:0]               col_reg;
    logic [CNT_W-1:0]               row_reg;
    logic [CNT_W-1:0]               col_next;
    logic [CNT_W-1:0]               row_next;

    logic                           s1_valid_reg;
    logic [mtsw_pkg::PIXEL_W-1:0]   s1_pixel_reg;
    mtsw_pkg::pos_t                 s1_pos_reg;
    logic                           s1_last_reg;

    logic                           out_valid_reg;
    logic [mtsw_pkg::OFFSET_W-1:0]  out_offset_reg;
    logic [mtsw_pkg::PIXEL_W-1:0]   out_pixel_reg;
    logic                           out_last_reg;
    logic                           out_oor_reg;

    logic [DIM_W-1:0]               w_eff;
    logic [DIM_W-1:0]               h_eff;
    logic [DIM_W-1:0]               col_inc;
    logic [DIM_W-1:0]               row_inc;
    logic                           col_wrap;
    logic                           row_wrap;
    logic                           last_next;
    logic                           src_fire;
    logic                           out_free;
    logic                           s1_move;
    logic [mtsw_pkg::OFFSET_W-1:0]  addr_offset;
    logic                           addr_oor;

    // size of 0 acts as 1, anything past the max acts as the max
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [mtsw_pkg::SIZE_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (int'(v) > mtsw_pkg::MAX_DIM)
        begin
            r = DIM_W'(mtsw_pkg::MAX_DIM);
        end
        else
        begin
            r = DIM_W'(v);
        end
        return r;
    endfunction

    // config decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x       <= '0;
            cfg_reg.origin_y       <= '0;
            cfg_reg.region_width   <= mtsw_pkg::SIZE_W'(1);
            cfg_reg.region_height  <= mtsw_pkg::SIZE_W'(1);
            cfg_reg.surface_width  <= mtsw_pkg::SIZE_W'(8);
            cfg_reg.surface_height <= mtsw_pkg::SIZE_W'(8);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mtsw_pkg::REG_ORIGIN_X:
                    cfg_reg.origin_x <= cfg_data[mtsw_pkg::ORG_W-1:0];
                mtsw_pkg::REG_ORIGIN_Y:
                    cfg_reg.origin_y <= cfg_data[mtsw_pkg::ORG_W-1:0];
                mtsw_pkg::REG_REGION_WIDTH:
                    cfg_reg.region_width <= cfg_data[mtsw_pkg::SIZE_W-1:0];
                mtsw_pkg::REG_REGION_HEIGHT:
                    cfg_reg.region_height <= cfg_data[mtsw_pkg::SIZE_W-1:0];
                mtsw_pkg::REG_SURFACE_WIDTH:
                    cfg_reg.surface_width <= cfg_data[mtsw_pkg::SIZE_W-1:0];
                mtsw_pkg::REG_SURFACE_HEIGHT:
                    cfg_reg.surface_height <= cfg_data[mtsw_pkg::SIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // handshake
    assign out_free  = !out_valid_reg || dst.ready;
    assign s1_move   = s1_valid_reg && out_free;
    assign src.ready = !s1_valid_reg || out_free;
    assign src_fire  = src.valid && src.ready;

    // raster position counters
    assign w_eff    = clamp_dim(cfg_reg.region_width);
    assign h_eff    = clamp_dim(cfg_reg.region_height);
    assign col_inc  = DIM_W'(col_reg) + DIM_W'(1);
    assign row_inc  = DIM_W'(row_reg) + DIM_W'(1);
    assign col_wrap = col_inc >= w_eff;
    assign row_wrap = row_inc >= h_eff;
    assign last_next = col_wrap && row_wrap;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_wrap)
        begin
            col_next = '0;
            row_next = row_wrap ? '0 : row_inc[CNT_W-1:0];
        end
        else
        begin
            col_next = col_inc[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (src_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (src.ready)
        begin
            s1_valid_reg <= src.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_fire)
        begin
            s1_pixel_reg   <= src.pixel_in;
            s1_pos_reg.col <= col_reg;
            s1_pos_reg.row <= row_reg;
            s1_last_reg    <= last_next;
        end
    end

    mtsw_addr u_addr
    (
        .cfg          (cfg_reg),
        .pos          (s1_pos_reg),
        .tiled_offset (addr_offset),
        .out_of_range (addr_oor)
    );

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_offset_reg <= addr_offset;
            out_pixel_reg  <= {s1_pixel_reg[7:0], s1_pixel_reg[15:8],
                               s1_pixel_reg[23:16], s1_pixel_reg[31:24]};
            out_last_reg   <= s1_last_reg;
            out_oor_reg    <= addr_oor;
        end
    end

    assign dst.valid        = out_valid_reg;
    assign dst.tiled_offset = out_offset_reg;
    assign dst.pixel_out    = out_pixel_reg;
    assign dst.region_last  = out_last_reg;
    assign dst.out_of_range = out_oor_reg;

    `ASSERT_NEXT(a_s1_drains, clk, rst_n, s1_move, out_valid_reg)
    `ASSERT_NEXT(a_result_held, clk, rst_n, out_valid_reg && !dst.ready, out_valid_reg)
    `ASSERT_IMPLY(a_full_blocks, clk, rst_n, s1_valid_reg && out_valid_reg && !dst.ready, !src.ready)
    `ASSERT_NEXT(a_col_wraps, clk, rst_n, src_fire && col_wrap, col_reg == '0)
    `ASSERT_NEXT(a_last_resets, clk, rst_n, src_fire && last_next, (row_reg == '0) && s1_last_reg)

endmodule
